### src/cpu_bus_decode_with_oam_dma_core_assert.svh
// ----------------------------------------------------------------------------
// CPU bus decoder assertion macros
// Shared assertion wrappers for the CPU bus decoder modules.
// ----------------------------------------------------------------------------
`ifndef CPU_BUS_DECODE_WITH_OAM_DMA_CORE_ASSERT_SVH
`define CPU_BUS_DECODE_WITH_OAM_DMA_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define CBD_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cbd assertion failed");
`define CBD_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("cbd assertion failed");
`else
`define CBD_ASSERT(name, clk, rst_n, prop)
`define CBD_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

### src/cbd_pkg.sv
// ----------------------------------------------------------------------------
// CPU bus decoder package
// Types, codes, address map constants and helpers for the bus decoder.
// ----------------------------------------------------------------------------
package cbd_pkg;

    localparam int RAM_DEPTH_DEF    = 2048;
    localparam int SPRITE_BYTES_DEF = 256;

    // Quotient of a 13-bit address by the smallest RAM depth fits in this many bits.
    localparam int SLOT_STEPS = 5;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] VREQ_NONE  = 2'd0;
    localparam logic [1:0] VREQ_READ  = 2'd1;
    localparam logic [1:0] VREQ_WRITE = 2'd2;

    localparam logic [15:0] ADDR_RAM_LAST   = 16'h1FFF;
    localparam logic [15:0] ADDR_VIDEO_LAST = 16'h3FFF;
    localparam logic [15:0] ADDR_DMA        = 16'h4014;
    localparam logic [15:0] ADDR_JOYPAD     = 16'h4016;
    localparam logic [15:0] ADDR_CART_FIRST = 16'h4017;
    localparam logic [7:0]  DMA_PAGE_LAST   = 8'h1F;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic accept;
        logic commit;
        logic clear_step;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_dp_status;

    // Mirrored RAM slot: a 13-bit address reduced modulo the RAM depth.
    function automatic logic [12:0] ram_slot(logic [12:0] addr, int depth);
        logic [17:0] rem;
        logic [17:0] step;
        rem = {5'b0, addr};
        for (int k = SLOT_STEPS - 1; k >= 0; k--) begin
            step = 18'(depth) << k;
            if (rem >= step) begin
                rem = rem - step;
            end
        end
        return rem[12:0];
    endfunction

endpackage

### src/cbd_in_if.sv
// ----------------------------------------------------------------------------
// CPU bus decoder input channel
// Valid/ready channel carrying one bus access or cycle tick.
// ----------------------------------------------------------------------------
interface cbd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] address;
    logic [7:0]  data;
    logic [7:0]  buttons;

    modport source (output valid, output opcode, output address, output data,
                    output buttons, input ready);
    modport sink (input valid, input opcode, input address, input data,
                  input buttons, output ready);
endinterface

### src/cbd_out_if.sv
// ----------------------------------------------------------------------------
// CPU bus decoder output channel
// Valid/ready channel carrying the result of one bus transaction.
// ----------------------------------------------------------------------------
interface cbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [1:0] video_request;
    logic [2:0] video_register;
    logic [7:0] video_write_data;
    logic       cartridge_read;
    logic       sprite_write;
    logic [7:0] sprite_index;
    logic [7:0] sprite_data;
    logic       dma_busy;

    modport source (output valid, output read_data, output video_request,
                    output video_register, output video_write_data,
                    output cartridge_read, output sprite_write, output sprite_index,
                    output sprite_data, output dma_busy, input ready);
    modport sink (input valid, input read_data, input video_request,
                  input video_register, input video_write_data,
                  input cartridge_read, input sprite_write, input sprite_index,
                  input sprite_data, input dma_busy, output ready);
endinterface

### src/cbd_ctrl.sv
// ----------------------------------------------------------------------------
// CPU bus decoder controller
// Sequences the RAM clear after reset and the accept/execute steps of each
// transaction.
// ----------------------------------------------------------------------------
`include "cpu_bus_decode_with_oam_dma_core_assert.svh"

module cbd_ctrl
    import cbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_dp_status i_status,
    output logic       o_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_ready          = 1'b0;
        o_cmd.accept     = 1'b0;
        o_cmd.commit     = 1'b0;
        o_cmd.clear_step = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
            end
            ST_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
            end
            ST_EXEC: begin
                o_cmd.commit = i_status.out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    `CBD_ASSERT(a_accept_to_exec, i_clk, i_rst_n, o_cmd.accept |=> (r_state == ST_EXEC))
    `CBD_ASSERT(a_commit_needs_room, i_clk, i_rst_n, o_cmd.commit |-> i_status.out_free)
    `CBD_ASSERT(a_clear_ends_idle, i_clk, i_rst_n, (o_cmd.clear_step && i_status.clear_last) |=> (r_state == ST_IDLE))

endmodule

### src/cbd_dpath.sv
// ----------------------------------------------------------------------------
// CPU bus decoder datapath
// Work RAM, controller shift register, sprite DMA state and result register.
// ----------------------------------------------------------------------------
`include "cpu_bus_decode_with_oam_dma_core_assert.svh"

module cbd_dpath
    import cbd_pkg::*;
#(
    parameter int RAM_DEPTH    = RAM_DEPTH_DEF,
    parameter int SPRITE_BYTES = SPRITE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [7:0]  i_buttons,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    cbd_out_if.source   o_result
);

    localparam int ADDR_W = $clog2(RAM_DEPTH);

    logic [7:0] r_ram [RAM_DEPTH];
    logic [7:0] r_rd_data;
    logic [ADDR_W-1:0] r_clr_cnt;

    logic [1:0]  r_opcode;
    logic [15:0] r_address;
    logic [7:0]  r_data;
    logic [7:0]  r_buttons;

    logic [7:0] r_button_shift, n_button_shift;
    logic       r_dma_active, n_dma_active;
    logic       r_dma_aligning, n_dma_aligning;
    logic [7:0] r_dma_page, n_dma_page;
    logic [7:0] r_dma_index, n_dma_index;
    logic [7:0] r_dma_byte, n_dma_byte;
    logic       r_cycle_parity, n_cycle_parity;

    logic       r_out_valid;
    logic [7:0] r_read_data, n_read_data;
    logic [1:0] r_video_request, n_video_request;
    logic [2:0] r_video_register, n_video_register;
    logic [7:0] r_video_write_data, n_video_write_data;
    logic       r_cartridge_read, n_cartridge_read;
    logic       r_sprite_write, n_sprite_write;
    logic [7:0] r_sprite_index, n_sprite_index;
    logic [7:0] r_sprite_data, n_sprite_data;

    logic [12:0]       cpu_rd_slot_full;
    logic [12:0]       dma_rd_slot_full;
    logic [12:0]       wr_slot_full;
    logic [ADDR_W-1:0] rd_slot;
    logic [ADDR_W-1:0] wr_slot;
    logic              exec_ram_we;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              dma_last;

    assign cpu_rd_slot_full = ram_slot(i_address[12:0], RAM_DEPTH);
    assign dma_rd_slot_full = ram_slot({r_dma_page[4:0], r_dma_index}, RAM_DEPTH);
    assign wr_slot_full     = ram_slot(r_address[12:0], RAM_DEPTH);
    assign rd_slot = (i_opcode == OP_TICK) ? dma_rd_slot_full[ADDR_W-1:0]
                                           : cpu_rd_slot_full[ADDR_W-1:0];
    assign wr_slot  = wr_slot_full[ADDR_W-1:0];
    assign dma_last = ({1'b0, r_dma_index} == 9'(SPRITE_BYTES - 1));

    assign o_status.clear_last = (r_clr_cnt == ADDR_W'(RAM_DEPTH - 1));
    assign o_status.out_free   = !r_out_valid || o_result.ready;

    assign ram_we    = i_cmd.clear_step || (i_cmd.commit && exec_ram_we);
    assign ram_waddr = i_cmd.clear_step ? r_clr_cnt : wr_slot;
    assign ram_wdata = i_cmd.clear_step ? 8'h00 : r_data;

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_ram[ram_waddr] <= ram_wdata;
        end
        if (i_cmd.accept) begin
            r_rd_data <= r_ram[rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear_step && !o_status.clear_last) begin
            r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_opcode  <= i_opcode;
            r_address <= i_address;
            r_data    <= i_data;
            r_buttons <= i_buttons;
        end
    end

    always_comb begin
        n_button_shift     = r_button_shift;
        n_dma_active       = r_dma_active;
        n_dma_aligning     = r_dma_aligning;
        n_dma_page         = r_dma_page;
        n_dma_index        = r_dma_index;
        n_dma_byte         = r_dma_byte;
        n_cycle_parity     = r_cycle_parity;
        n_read_data        = 8'h00;
        n_video_request    = VREQ_NONE;
        n_video_register   = 3'd0;
        n_video_write_data = 8'h00;
        n_cartridge_read   = 1'b0;
        n_sprite_write     = 1'b0;
        n_sprite_index     = 8'h00;
        n_sprite_data      = 8'h00;
        exec_ram_we        = 1'b0;
        case (r_opcode)
            OP_READ: begin
                if (r_address <= ADDR_RAM_LAST) begin
                    n_read_data = r_rd_data;
                end else if (r_address <= ADDR_VIDEO_LAST) begin
                    n_video_request  = VREQ_READ;
                    n_video_register = r_address[2:0];
                end else if (r_address == ADDR_JOYPAD) begin
                    n_read_data    = {7'b0, r_button_shift[7]};
                    n_button_shift = {r_button_shift[6:0], 1'b0};
                end else if (r_address >= ADDR_CART_FIRST) begin
                    n_cartridge_read = 1'b1;
                end
            end
            OP_WRITE: begin
                if (r_address <= ADDR_RAM_LAST) begin
                    exec_ram_we = 1'b1;
                end else if (r_address <= ADDR_VIDEO_LAST) begin
                    n_video_request    = VREQ_WRITE;
                    n_video_register   = r_address[2:0];
                    n_video_write_data = r_data;
                end else if (r_address == ADDR_DMA) begin
                    n_dma_active   = 1'b1;
                    n_dma_aligning = 1'b1;
                    n_dma_page     = r_data;
                    n_dma_index    = 8'h00;
                end else if (r_address == ADDR_JOYPAD) begin
                    n_button_shift = r_buttons;
                end
            end
            OP_TICK: begin
                if (r_dma_active) begin
                    if (r_dma_aligning) begin
                        if (r_cycle_parity) begin
                            n_dma_aligning = 1'b0;
                        end
                    end else if (!r_cycle_parity) begin
                        n_dma_byte = (r_dma_page <= DMA_PAGE_LAST) ? r_rd_data : 8'h00;
                    end else begin
                        n_sprite_write = 1'b1;
                        n_sprite_index = r_dma_index;
                        n_sprite_data  = r_dma_byte;
                        if (dma_last) begin
                            n_dma_index  = 8'h00;
                            n_dma_active = 1'b0;
                        end else begin
                            n_dma_index = r_dma_index + 8'd1;
                        end
                    end
                end
                n_cycle_parity = !r_cycle_parity;
            end
            default: begin
                n_cycle_parity = r_cycle_parity;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_button_shift <= 8'h00;
            r_dma_active   <= 1'b0;
            r_dma_aligning <= 1'b0;
            r_dma_page     <= 8'h00;
            r_dma_index    <= 8'h00;
            r_dma_byte     <= 8'h00;
            r_cycle_parity <= 1'b0;
        end else if (i_cmd.commit) begin
            r_button_shift <= n_button_shift;
            r_dma_active   <= n_dma_active;
            r_dma_aligning <= n_dma_aligning;
            r_dma_page     <= n_dma_page;
            r_dma_index    <= n_dma_index;
            r_dma_byte     <= n_dma_byte;
            r_cycle_parity <= n_cycle_parity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_read_data        <= n_read_data;
            r_video_request    <= n_video_request;
            r_video_register   <= n_video_register;
            r_video_write_data <= n_video_write_data;
            r_cartridge_read   <= n_cartridge_read;
            r_sprite_write     <= n_sprite_write;
            r_sprite_index     <= n_sprite_index;
            r_sprite_data      <= n_sprite_data;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.read_data        = r_read_data;
    assign o_result.video_request    = r_video_request;
    assign o_result.video_register   = r_video_register;
    assign o_result.video_write_data = r_video_write_data;
    assign o_result.cartridge_read   = r_cartridge_read;
    assign o_result.sprite_write     = r_sprite_write;
    assign o_result.sprite_index     = r_sprite_index;
    assign o_result.sprite_data      = r_sprite_data;
    assign o_result.dma_busy         = r_dma_active;

    `CBD_ASSERT(a_align_only_active, i_clk, i_rst_n, r_dma_aligning |-> r_dma_active)
    `CBD_ASSERT(a_index_in_range, i_clk, i_rst_n, ({1'b0, r_dma_index} < 9'(SPRITE_BYTES)))
    `CBD_ASSERT_ALWAYS(a_commit_fills_output, i_clk, (i_rst_n && i_cmd.commit) |=> r_out_valid)

endmodule

### src/cpu_bus_decode_with_oam_dma_core.sv
// ----------------------------------------------------------------------------
// CPU bus decoder with sprite DMA
// Decodes CPU bus reads, writes and cycle ticks, with mirrored work RAM,
// video register forwarding, controller port and sprite DMA.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction on i_item is a CPU read, a CPU write or one CPU
// cycle tick; each one produces exactly one result transaction on o_result.
// A transaction is accepted in the idle state and executed in the execute
// state, once the work RAM read issued at acceptance has returned and the
// output register is free. Its result is then registered in the output
// register; the block does not accept a new transaction until the current
// one has been executed.
// After reset the work RAM (RAM_DEPTH entries, 2048 by default) is cleared
// one entry per cycle; i_item.ready stays low until the clear is done.
// A finished result waits in the output register while the receiver stalls;
// the next transaction is still accepted, and its execution waits until the
// output register has been taken.
// ----------------------------------------------------------------------------
module cpu_bus_decode_with_oam_dma_core
    import cbd_pkg::*;
#(
    parameter int RAM_DEPTH    = RAM_DEPTH_DEF,
    parameter int SPRITE_BYTES = SPRITE_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cbd_in_if.sink    i_item,
    cbd_out_if.source o_result
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       ctrl_ready;

    assign i_item.ready = ctrl_ready;

    cbd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_item.valid),
        .i_status (dp_status),
        .o_ready  (ctrl_ready),
        .o_cmd    (dp_cmd)
    );

    cbd_dpath #(
        .RAM_DEPTH    (RAM_DEPTH),
        .SPRITE_BYTES (SPRITE_BYTES)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_opcode  (i_item.opcode),
        .i_address (i_item.address),
        .i_data    (i_item.data),
        .i_buttons (i_item.buttons),
        .i_cmd     (dp_cmd),
        .o_status  (dp_status),
        .o_result  (o_result)
    );

endmodule
